/* src/brrs_pkg.sv */
package brrs_pkg;

    localparam int unsigned SECONDS_BITS_DEF = 8;
    localparam int unsigned FIELD_W          = 8;
    localparam int unsigned TPS_W            = 10;
    localparam logic [TPS_W-1:0] TPS_RESET   = TPS_W'(1000);

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2
    } t_mode;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_RING = 2'd1;
    localparam logic [1:0] PHASE_REST = 2'd2;

endpackage

/* src/brrs_in_if.sv */
interface brrs_in_if import brrs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [FIELD_W-1:0] ring_seconds;
    logic [FIELD_W-1:0] rest_seconds;
    logic [FIELD_W-1:0] ring_count;

    modport source (output valid, mode, ring_seconds, rest_seconds, ring_count,
                    input ready);
    modport sink   (input valid, mode, ring_seconds, rest_seconds, ring_count,
                    output ready);
endinterface

/* src/brrs_out_if.sv */
interface brrs_out_if import brrs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               bell_level;
    logic [1:0]         phase;
    logic [FIELD_W-1:0] rings_left;
    logic               endless;
    logic               start_held;
    logic               sequence_done;

    modport source (output valid, bell_level, phase, rings_left, endless, start_held,
                    sequence_done, input ready);
    modport sink   (input valid, bell_level, phase, rings_left, endless, start_held,
                    sequence_done, output ready);
endinterface

/* src/bell_ring_rest_sequencer.sv */
// Bell ring/rest sequencer.
// Input channel i_in carries tick, start and stop items; output channel o_out
// returns one status item per transfer in: bell level, phase, rings left,
// endless flag, held-start flag and a sequence-done pulse.
// ticks_per_second is written through i_cfg_we/i_cfg_wdata; the user must write it
// only while the block is idle, which the block does not enforce; 0 counts as 1.
// The registered status for an input transfer is valid on o_out in the cycle
// after the transfer. Throughput: one item per cycle unless o_out stalls; an
// item's update is one pass through one seconds-by-rate multiplier and counters.
// The input stays ready while the output register is empty or being emptied,
// so a stalled receiver holds one finished status and stops input after it.
// Reset (synchronous, active low) returns to idle with no held start, an
// empty output register and ticks_per_second at 1000.
module bell_ring_rest_sequencer import brrs_pkg::*; #(
    parameter int unsigned SECONDS_BITS = SECONDS_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [TPS_W-1:0]    i_cfg_wdata,
    brrs_in_if.sink             i_in,
    brrs_out_if.source          o_out
);

    localparam int unsigned SW    = SECONDS_BITS;
    localparam int unsigned LEN_W = SW + TPS_W;
    localparam int unsigned CW    = (SW > FIELD_W) ? SW : FIELD_W;
    localparam logic [CW-1:0] SEC_TOP = CW'((64'd1 << SW) - 64'd1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RING = 3'b010,
        ST_REST = 3'b100
    } t_state;

    function automatic logic [SW-1:0] clamp_secs(input logic [FIELD_W-1:0] s);
        logic [CW-1:0] wide;
        wide = CW'(s);
        return (wide > SEC_TOP) ? SW'(SEC_TOP) : SW'(wide);
    endfunction

    logic [TPS_W-1:0]   r_tps;
    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_ticks, n_ticks;
    logic [FIELD_W-1:0] r_rings, n_rings;
    logic               r_forever, n_forever;
    logic [SW-1:0]      r_ring_t, n_ring_t;
    logic [SW-1:0]      r_rest_t, n_rest_t;
    logic               r_held_valid, n_held_valid;
    logic [SW-1:0]      r_held_ring, n_held_ring;
    logic [SW-1:0]      r_held_rest, n_held_rest;
    logic [FIELD_W-1:0] r_held_rep, n_held_rep;

    logic               r_out_valid;
    logic               r_bell;
    logic [1:0]         r_phase;
    logic [FIELD_W-1:0] r_rings_left;
    logic               r_endless;
    logic               r_start_held;
    logic               r_done;

    logic               in_ready;
    logic               in_xfer;
    logic [SW-1:0]      in_ring;
    logic [SW-1:0]      in_rest;
    logic [TPS_W-1:0]   tps_eff;
    logic [FIELD_W-1:0] rings_dec;
    logic               seq_end;
    logic [LEN_W-1:0]   ticks_dec;
    logic [SW-1:0]      sel_secs;
    logic [LEN_W-1:0]   prod;
    logic [LEN_W-1:0]   len;
    logic               done;

    assign in_ready = !r_out_valid || o_out.ready;
    assign in_xfer  = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    assign in_ring = clamp_secs(i_in.ring_seconds);
    assign in_rest = clamp_secs(i_in.rest_seconds);
    assign tps_eff = (r_tps == '0) ? TPS_W'(1) : r_tps;

    assign rings_dec = (!r_forever && r_rings != '0) ? r_rings - FIELD_W'(1) : r_rings;
    assign seq_end   = !r_forever && rings_dec == '0;
    assign ticks_dec = (r_ticks != '0) ? r_ticks - LEN_W'(1) : r_ticks;

    // pick the seconds of whichever phase could begin on this item
    always_comb begin
        unique case (r_state)
            ST_RING: sel_secs = seq_end ? r_held_ring : r_rest_t;
            ST_REST: sel_secs = r_held_valid ? r_held_ring : r_ring_t;
            default: sel_secs = in_ring;
        endcase
    end

    assign prod = LEN_W'(sel_secs) * LEN_W'(tps_eff);
    assign len  = (prod == '0) ? LEN_W'(1) : prod;

    always_comb begin
        n_state      = r_state;
        n_ticks      = r_ticks;
        n_rings      = r_rings;
        n_forever    = r_forever;
        n_ring_t     = r_ring_t;
        n_rest_t     = r_rest_t;
        n_held_valid = r_held_valid;
        n_held_ring  = r_held_ring;
        n_held_rest  = r_held_rest;
        n_held_rep   = r_held_rep;
        done         = 1'b0;
        if (in_xfer) begin
            case (i_in.mode)
                MODE_START: begin
                    if (r_state == ST_IDLE) begin
                        n_state   = ST_RING;
                        n_ticks   = len;
                        n_rings   = i_in.ring_count;
                        n_forever = (i_in.ring_count == '0);
                        n_ring_t  = in_ring;
                        n_rest_t  = in_rest;
                    end else begin
                        n_held_valid = 1'b1;
                        n_held_ring  = in_ring;
                        n_held_rest  = in_rest;
                        n_held_rep   = i_in.ring_count;
                    end
                end
                MODE_STOP: begin
                    n_state      = ST_IDLE;
                    n_ticks      = '0;
                    n_rings      = '0;
                    n_forever    = 1'b0;
                    n_held_valid = 1'b0;
                end
                MODE_TICK: begin
                    if (r_state != ST_IDLE) begin
                        n_ticks = ticks_dec;
                        if (ticks_dec == '0) begin
                            if (r_state == ST_RING) begin
                                n_rings = rings_dec;
                                if (seq_end) begin
                                    done = 1'b1;
                                    if (!r_held_valid) begin
                                        n_state   = ST_IDLE;
                                        n_rings   = '0;
                                        n_forever = 1'b0;
                                    end
                                end else begin
                                    n_state = ST_REST;
                                    n_ticks = len;
                                end
                            end else if (!r_held_valid) begin
                                n_state = ST_RING;
                                n_ticks = len;
                            end
                            // launch the held start at a sequence end or rest end
                            if (r_held_valid && (r_state == ST_REST || seq_end)) begin
                                n_state      = ST_RING;
                                n_ticks      = len;
                                n_rings      = r_held_rep;
                                n_forever    = (r_held_rep == '0);
                                n_ring_t     = r_held_ring;
                                n_rest_t     = r_held_rest;
                                n_held_valid = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps        <= TPS_RESET;
            r_state      <= ST_IDLE;
            r_ticks      <= '0;
            r_rings      <= '0;
            r_forever    <= 1'b0;
            r_ring_t     <= '0;
            r_rest_t     <= '0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
            r_state      <= n_state;
            r_ticks      <= n_ticks;
            r_rings      <= n_rings;
            r_forever    <= n_forever;
            r_ring_t     <= n_ring_t;
            r_rest_t     <= n_rest_t;
            r_held_valid <= n_held_valid;
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: held start fields and the status item
    always_ff @(posedge i_clk) begin
        r_held_ring <= n_held_ring;
        r_held_rest <= n_held_rest;
        r_held_rep  <= n_held_rep;
        if (in_xfer) begin
            r_bell       <= (n_state == ST_RING);
            r_phase      <= (n_state == ST_RING) ? PHASE_RING :
                            (n_state == ST_REST) ? PHASE_REST : PHASE_IDLE;
            r_rings_left <= n_forever ? '0 : n_rings;
            r_endless    <= n_forever;
            r_start_held <= n_held_valid;
            r_done       <= done;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.bell_level    = r_bell;
    assign o_out.phase         = r_phase;
    assign o_out.rings_left    = r_rings_left;
    assign o_out.endless       = r_endless;
    assign o_out.start_held    = r_start_held;
    assign o_out.sequence_done = r_done;

endmodule

/* dv/testbench.sv */
module testbench;
    import brrs_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int N_DIR = 26;

    typedef struct packed {
        logic       bell;
        logic [1:0] phase;
        logic [7:0] rings;
        logic       endless;
        logic       held;
        logic       done;
    } t_status;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] ring;
        logic [7:0] rest;
        logic [7:0] rep;
        logic       typed;
        t_status    want;
    } t_dir_row;

    localparam t_status ST_IDLE = '{1'b0, PHASE_IDLE, 8'd0, 1'b0, 1'b0, 1'b0};

    // Runs at the reset rate of 1000 ticks per second; zero lengths make one-tick phases.
    t_dir_row dir_rows [N_DIR] = '{
        '{MODE_TICK,   8'd0,   8'd0,   8'd0,   1'b1, ST_IDLE},
        '{MODE_UNUSED, 8'd255, 8'd255, 8'd255, 1'b1, ST_IDLE},
        '{MODE_STOP,   8'd255, 8'd255, 8'd255, 1'b1, ST_IDLE},
        '{MODE_START,  8'd0,   8'd0,   8'd1,   1'b1, '{1'b1, PHASE_RING, 8'd1, 1'b0, 1'b0, 1'b0}},
        '{MODE_TICK,   8'd0,   8'd0,   8'd0,   1'b1, '{1'b0, PHASE_IDLE, 8'd0, 1'b0, 1'b0, 1'b1}},
        '{MODE_START,  8'd0,   8'd0,   8'd2,   1'b1, '{1'b1, PHASE_RING, 8'd2, 1'b0, 1'b0, 1'b0}},
        '{MODE_START,  8'd255, 8'd255, 8'd255, 1'b1, '{1'b1, PHASE_RING, 8'd2, 1'b0, 1'b1, 1'b0}},
        '{MODE_START,  8'd0,   8'd0,   8'd0,   1'b1, '{1'b1, PHASE_RING, 8'd2, 1'b0, 1'b1, 1'b0}},
        '{MODE_TICK,   8'd0,   8'd0,   8'd0,   1'b1, '{1'b0, PHASE_REST, 8'd1, 1'b0, 1'b1, 1'b0}},
        '{MODE_TICK,   8'd0,   8'd0,   8'd0,   1'b1, '{1'b1, PHASE_RING, 8'd0, 1'b1, 1'b0, 1'b0}},
        '{MODE_TICK,   8'd0,   8'd0,   8'd0,   1'b1, '{1'b0, PHASE_REST, 8'd0, 1'b1, 1'b0, 1'b0}},
        '{MODE_TICK,   8'd0,   8'd0,   8'd0,   1'b1, '{1'b1, PHASE_RING, 8'd0, 1'b1, 1'b0, 1'b0}},
        '{MODE_UNUSED, 8'd1,   8'd2,   8'd3,   1'b1, '{1'b1, PHASE_RING, 8'd0, 1'b1, 1'b0, 1'b0}},
        '{MODE_STOP,   8'd0,   8'd0,   8'd0,   1'b1, ST_IDLE},
        '{MODE_START,  8'd255, 8'd255, 8'd255, 1'b1, '{1'b1, PHASE_RING, 8'd255, 1'b0, 1'b0, 1'b0}},
        '{MODE_TICK,   8'd0,   8'd0,   8'd0,   1'b0, ST_IDLE},
        '{MODE_START,  8'd170, 8'd85,  8'd3,   1'b0, ST_IDLE},
        '{MODE_STOP,   8'd0,   8'd0,   8'd0,   1'b1, ST_IDLE},
        '{MODE_START,  8'd0,   8'd255, 8'd2,   1'b1, '{1'b1, PHASE_RING, 8'd2, 1'b0, 1'b0, 1'b0}},
        '{MODE_TICK,   8'd0,   8'd0,   8'd0,   1'b1, '{1'b0, PHASE_REST, 8'd1, 1'b0, 1'b0, 1'b0}},
        '{MODE_START,  8'd0,   8'd0,   8'd1,   1'b0, ST_IDLE},
        '{MODE_STOP,   8'd0,   8'd0,   8'd0,   1'b1, ST_IDLE},
        '{MODE_START,  8'd0,   8'd0,   8'd1,   1'b1, '{1'b1, PHASE_RING, 8'd1, 1'b0, 1'b0, 1'b0}},
        '{MODE_START,  8'd0,   8'd0,   8'd3,   1'b0, ST_IDLE},
        '{MODE_TICK,   8'd0,   8'd0,   8'd0,   1'b1, '{1'b1, PHASE_RING, 8'd3, 1'b0, 1'b0, 1'b1}},
        '{MODE_STOP,   8'd0,   8'd0,   8'd0,   1'b1, ST_IDLE}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [TPS_W-1:0] i_cfg_wdata;

    brrs_in_if  in_ch ();
    brrs_out_if out_ch ();

    bell_ring_rest_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // sequencer state as the block should hold it
    logic [TPS_W-1:0] cur_rate = TPS_RESET;
    logic [1:0]       cur_phase = PHASE_IDLE;
    logic [17:0]      ticks_left = '0;
    logic [7:0]       rings_to_go = '0;
    logic             rings_endless = 1'b0;
    logic [7:0]       ring_secs = '0;
    logic [7:0]       rest_secs = '0;
    logic             pend_valid = 1'b0;
    logic [7:0]       pend_ring = '0;
    logic [7:0]       pend_rest = '0;
    logic [7:0]       pend_rep = '0;

    t_status     status_due [$];
    int unsigned mismatches = 0;
    int unsigned n_sent = 0;
    int unsigned rx_count = 0;
    int unsigned n_seq_done = 0;
    int unsigned n_held_taken = 0;
    bit          tx_idles = 1'b1;
    bit          rx_idles = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1600000;
        $display("bell_ring_rest_sequencer test failed");
        $finish;
    end

    function automatic logic [17:0] phase_ticks(input logic [7:0] secs);
        logic [17:0] len;
        len = 18'(secs) * 18'((cur_rate == '0) ? 10'd1 : cur_rate);
        return (len == '0) ? 18'd1 : len;
    endfunction

    function automatic void launch(input logic [7:0] ring, input logic [7:0] rest,
                                   input logic [7:0] rep);
        ring_secs     = ring;
        rest_secs     = rest;
        rings_to_go   = rep;
        rings_endless = (rep == '0);
        cur_phase     = PHASE_RING;
        ticks_left    = phase_ticks(ring);
    endfunction

    function automatic void take_held_or_idle();
        if (pend_valid) begin
            pend_valid = 1'b0;
            n_held_taken++;
            launch(pend_ring, pend_rest, pend_rep);
        end else begin
            cur_phase     = PHASE_IDLE;
            ticks_left    = '0;
            rings_to_go   = '0;
            rings_endless = 1'b0;
        end
    endfunction

    function automatic t_status step_sequencer(input logic [1:0] mode, input logic [7:0] ring,
                                               input logic [7:0] rest, input logic [7:0] rep);
        t_status s;
        logic    ended;
        ended = 1'b0;
        case (mode)
            MODE_START: begin
                if (cur_phase == PHASE_IDLE) begin
                    launch(ring, rest, rep);
                end else begin
                    pend_valid = 1'b1;
                    pend_ring  = ring;
                    pend_rest  = rest;
                    pend_rep   = rep;
                end
            end
            MODE_STOP: begin
                cur_phase     = PHASE_IDLE;
                ticks_left    = '0;
                rings_to_go   = '0;
                rings_endless = 1'b0;
                pend_valid    = 1'b0;
            end
            MODE_TICK: begin
                if (cur_phase != PHASE_IDLE) begin
                    if (ticks_left != '0) ticks_left--;
                    if (ticks_left == '0) begin
                        if (cur_phase == PHASE_RING) begin
                            if (!rings_endless && rings_to_go != '0) rings_to_go--;
                            if (!rings_endless && rings_to_go == '0) begin
                                ended = 1'b1;
                                n_seq_done++;
                                take_held_or_idle();
                            end else begin
                                cur_phase  = PHASE_REST;
                                ticks_left = phase_ticks(rest_secs);
                            end
                        end else if (pend_valid) begin
                            take_held_or_idle();
                        end else begin
                            cur_phase  = PHASE_RING;
                            ticks_left = phase_ticks(ring_secs);
                        end
                    end
                end
            end
            default: ;
        endcase
        s.bell    = (cur_phase == PHASE_RING);
        s.phase   = cur_phase;
        s.rings   = rings_endless ? 8'd0 : rings_to_go;
        s.endless = rings_endless;
        s.held    = pend_valid;
        s.done    = ended;
        return s;
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic send_item(input logic [1:0] mode, input logic [7:0] ring,
                             input logic [7:0] rest, input logic [7:0] rep,
                             input logic typed, input t_status want);
        t_status predicted;
        predicted = step_sequencer(mode, ring, rest, rep);
        status_due.push_back(typed ? want : predicted);
        n_sent++;
        if (tx_idles && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= mode;
        in_ch.ring_seconds <= ring;
        in_ch.rest_seconds <= rest;
        in_ch.ring_count   <= rep;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [TPS_W-1:0] rate);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= rate;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_rate = rate;
    endtask

    function automatic logic [7:0] pick_secs();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3) return 8'($urandom);
        // keep phases short at high rates so sequences still finish
        if (cur_rate > 10'd4) return 8'd0;
        return 8'($urandom_range(0, 3));
    endfunction

    function automatic logic [7:0] pick_repeat();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) return 8'd0;
        if (r < 92) return 8'($urandom_range(1, 4));
        return 8'($urandom);
    endfunction

    task automatic run_random(input int unsigned count);
        int unsigned r;
        logic [1:0]  mode;
        logic [7:0]  ring;
        logic [7:0]  rest;
        logic [7:0]  rep;
        for (int unsigned k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 78) mode = MODE_TICK;
            else if (r < 90) mode = MODE_START;
            else if (r < 96) mode = MODE_STOP;
            else mode = MODE_UNUSED;
            if (mode == MODE_START) begin
                ring = pick_secs();
                rest = pick_secs();
                rep  = pick_repeat();
            end else begin
                ring = 8'($urandom);
                rest = 8'($urandom);
                rep  = 8'($urandom);
            end
            send_item(mode, ring, rest, rep, 1'b0, ST_IDLE);
        end
        // leave the sequencer idle before the next rate change
        send_item(MODE_STOP, 8'd0, 8'd0, 8'd0, 1'b0, ST_IDLE);
        in_ch.valid <= 1'b0;
    endtask

    task automatic compare_status(input t_status want);
        if (out_ch.bell_level !== want.bell) begin
            $error("bell_level: expected %0d, got %0d", want.bell, out_ch.bell_level);
            mismatches++;
        end
        if (out_ch.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, out_ch.phase);
            mismatches++;
        end
        if (out_ch.rings_left !== want.rings) begin
            $error("rings_left: expected %0d, got %0d", want.rings, out_ch.rings_left);
            mismatches++;
        end
        if (out_ch.endless !== want.endless) begin
            $error("endless: expected %0d, got %0d", want.endless, out_ch.endless);
            mismatches++;
        end
        if (out_ch.start_held !== want.held) begin
            $error("start_held: expected %0d, got %0d", want.held, out_ch.start_held);
            mismatches++;
        end
        if (out_ch.sequence_done !== want.done) begin
            $error("sequence_done: expected %0d, got %0d", want.done, out_ch.sequence_done);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            rx_count++;
            if (status_due.size() == 0) begin
                $error("status transfer with nothing outstanding");
                mismatches++;
            end else begin
                compare_status(status_due.pop_front());
            end
        end
    end

    initial begin : receiver
        bit held_off;
        held_off = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!held_off && rx_count >= 300) begin
                // long hold-off: input backs up and stalls
                held_off = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (120) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (rx_idles && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.mode         <= MODE_TICK;
        in_ch.ring_seconds <= '0;
        in_ch.rest_seconds <= '0;
        in_ch.ring_count   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIR; k++) begin
            send_item(dir_rows[k].mode, dir_rows[k].ring, dir_rows[k].rest, dir_rows[k].rep,
                      dir_rows[k].typed, dir_rows[k].want);
        end
        in_ch.valid <= 1'b0;

        write_rate(10'd1);
        run_random(400);
        write_rate(10'd0);
        run_random(250);
        write_rate(10'd1023);
        run_random(250);
        write_rate(10'd2);
        run_random(300);
        tx_idles = 1'b0;
        rx_idles = 1'b0;
        write_rate(10'd3);
        run_random(400);
        drain();

        $display("%0d items sent at rates 1000, 1, 0, 1023, 2 and 3; %0d status transfers checked",
                 n_sent, rx_count);
        $display("%0d counted sequences ended, %0d held starts taken over", n_seq_done,
                 n_held_taken);
        if (mismatches == 0) begin
            $display("bell_ring_rest_sequencer test passed");
        end else begin
            $display("bell_ring_rest_sequencer test failed");
        end
        $finish;
    end

endmodule
